[src/fgmc_pkg.sv]
// fgmc_pkg: sizes, types, opcodes and address helpers of the mapping cache
// used by fgmc_victim_scan and fine_grained_mapping_cache_top; no dependencies
package fgmc_pkg;

    // geometry (page and entry counts are powers of two)
    localparam int NUM_TPAGES       = 64;
    localparam int ENTRIES_PER_PAGE = 64;
    localparam int PPA_BITS         = 32;
    localparam int TOTAL_ENTRIES    = NUM_TPAGES * ENTRIES_PER_PAGE;

    // port field widths
    localparam int ADDR_W = 12;
    localparam int PHYS_W = 32;
    localparam int MAXC_W = 13;
    localparam int VPG_W  = 6;

    // derived widths
    localparam int PAGE_W = $clog2(NUM_TPAGES);
    localparam int OFF_W  = $clog2(ENTRIES_PER_PAGE);
    localparam int SLOT_W = PAGE_W + OFF_W;
    localparam int PCNT_W = $clog2(ENTRIES_PER_PAGE + 1);
    localparam int TOT_W  = $clog2(TOTAL_ENTRIES + 1);
    localparam int SCAN_W = $clog2(NUM_TPAGES + 1);
    localparam int CMP_W  = (TOT_W > MAXC_W) ? TOT_W : MAXC_W;

    localparam logic [MAXC_W-1:0] MAX_CACHED_RST = MAXC_W'(4096);

    typedef logic [1:0]          t_opcode;
    typedef logic [PAGE_W-1:0]   t_page;
    typedef logic [OFF_W-1:0]    t_off;
    typedef logic [SLOT_W-1:0]   t_slot;
    typedef logic [PCNT_W-1:0]   t_pcnt;
    typedef logic [TOT_W-1:0]    t_tot;
    typedef logic [PPA_BITS-1:0] t_ppa;

    localparam t_opcode OP_LOOKUP = 2'd0;
    localparam t_opcode OP_FILL   = 2'd1;
    localparam t_opcode OP_UPDATE = 2'd2;

    // one translation page: cached bits, cached count, dirty mark
    typedef struct packed {
        logic [ENTRIES_PER_PAGE-1:0] bits;
        t_pcnt                       cnt;
        logic                        dirty;
    } t_page_row;

    // page count stream into the victim scan
    typedef struct packed {
        logic  clr;
        logic  vld;
        t_page idx;
        t_pcnt cnt;
        logic  dirty;
    } t_scan_req;

    // victim chosen by the scan
    typedef struct packed {
        logic  found;
        t_page page;
        t_pcnt best;
        logic  dirty;
    } t_scan_res;

    // translation page of a logical address, wrapped to the page count
    function automatic t_page addr_page(input logic [ADDR_W-1:0] addr);
        logic [31:0] wide;
        wide = 32'(addr) >> OFF_W;
        return t_page'(wide);
    endfunction

    // entry within its translation page
    function automatic t_off addr_off(input logic [ADDR_W-1:0] addr);
        return t_off'(addr);
    endfunction

endpackage

[src/fine_grained_mapping_cache_top.sv]
// fine_grained_mapping_cache_top: mapping cache with map and page memories,
// request sequencer and output register; uses fgmc_pkg and fgmc_victim_scan
// A request is taken in the idle state, which starts the memory reads; lookup, update
// and fill without eviction finish in the read step, with any write-back to memory.
// A fill that finds the cache full walks the page memory one row a cycle, then evicts
// the victim page and fills; every result waits until the output register is free.
// Reset clears all TOTAL_ENTRIES (4096) map entries and the page memory with
// o_ready low; max_cached writes are taken always.
module fine_grained_mapping_cache_top
    import fgmc_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    // request channel
    input  logic              i_valid,
    output logic              o_ready,
    input  logic [1:0]        i_opcode,
    input  logic [ADDR_W-1:0] i_logical_addr,
    input  logic [PHYS_W-1:0] i_new_phys_addr,
    // result channel
    output logic              o_valid,
    input  logic              i_ready,
    output logic              o_hit,
    output logic [PHYS_W-1:0] o_phys_addr,
    output logic              o_evicted,
    output logic [VPG_W-1:0]  o_victim_page,
    output logic              o_victim_dirty,
    output logic              o_cache_full,
    // max_cached write channel
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [MAXC_W-1:0] i_cfg_data
);

    localparam logic [2:0] S_CLEAR = 3'd0;
    localparam logic [2:0] S_IDLE  = 3'd1;
    localparam logic [2:0] S_RD    = 3'd2;
    localparam logic [2:0] S_SCAN  = 3'd3;
    localparam logic [2:0] S_EVICT = 3'd4;
    localparam logic [2:0] S_FILL  = 3'd5;

    // control registers
    logic [2:0]        r_state, n_state;
    t_slot             r_clr, n_clr;
    t_tot              r_total, n_total;
    logic [MAXC_W-1:0] r_max;
    logic [SCAN_W-1:0] r_idx, n_idx;
    logic              r_sv, n_sv;
    logic              r_ovalid;

    // request payload
    t_opcode r_op;
    t_page   r_page;
    t_off    r_off;
    t_ppa    r_ppa;
    logic    r_hit, n_hit;
    t_page   r_sidx, n_sidx;

    // result payload
    logic              r_o_hit;
    logic [PHYS_W-1:0] r_o_phys;
    logic              r_o_ev;
    logic [VPG_W-1:0]  r_o_vpage;
    logic              r_o_vdirty;
    logic              r_o_full;

    // memories
    t_ppa      r_map_mem [TOTAL_ENTRIES];
    t_ppa      r_map_q;
    t_page_row r_page_mem [NUM_TPAGES];
    t_page_row r_page_q;

    // memory ports
    logic      map_we, map_re, page_we, page_re;
    t_slot     map_wa, map_ra;
    t_ppa      map_wd;
    t_page     page_wa, page_ra;
    t_page_row page_wd;

    // sequencer signals
    t_page     in_page;
    t_off      in_off;
    t_slot     r_slot;
    logic      accept, out_free, load;
    t_scan_req scan_req;
    t_scan_res scan_res;

    logic              res_hit, res_ev, res_vdirty;
    logic [PHYS_W-1:0] res_phys;
    logic [VPG_W-1:0]  res_vpage;

    assign in_page  = addr_page(i_logical_addr);
    assign in_off   = addr_off(i_logical_addr);
    assign r_slot   = {r_page, r_off};
    assign o_ready  = (r_state == S_IDLE);
    assign accept   = i_valid && o_ready;
    assign out_free = !r_ovalid || i_ready;
    assign o_cfg_ready = 1'b1;

    fgmc_victim_scan u_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_req   (scan_req),
        .o_res   (scan_res)
    );

    // sequencer: reads, modifies and writes back the two memories
    always_comb begin
        t_page_row row;
        t_page_row fill_row;
        logic      fill_new;
        logic      cur_hit;
        logic      fin;
        logic      full_now;

        n_state = r_state;
        n_clr   = r_clr;
        n_total = r_total;
        n_idx   = r_idx;
        n_sv    = 1'b0;
        n_sidx  = r_sidx;
        n_hit   = r_hit;

        map_we  = 1'b0;
        map_wa  = r_slot;
        map_wd  = r_ppa;
        map_re  = 1'b0;
        map_ra  = {in_page, in_off};
        page_we = 1'b0;
        page_wa = r_page;
        page_wd = r_page_q;
        page_re = 1'b0;
        page_ra = in_page;

        fin        = 1'b0;
        res_hit    = r_hit;
        res_phys   = '0;
        res_ev     = 1'b0;
        res_vpage  = '0;
        res_vdirty = 1'b0;

        scan_req       = '0;
        scan_req.vld   = r_sv;
        scan_req.idx   = r_sidx;
        scan_req.cnt   = r_page_q.cnt;
        scan_req.dirty = r_page_q.dirty;

        cur_hit  = r_page_q.bits[r_off];
        full_now = (CMP_W'(r_total) >= CMP_W'(r_max));

        // row to be filled; a row just evicted reads as empty
        if ((r_state == S_FILL) && scan_res.found && (scan_res.page == r_page)) begin
            row = '0;
        end else begin
            row = r_page_q;
        end
        fill_new          = !row.bits[r_off];
        fill_row          = row;
        fill_row.bits[r_off] = 1'b1;
        fill_row.cnt      = t_pcnt'(row.cnt + 1'b1);

        case (r_state)
            S_CLEAR: begin
                map_we  = 1'b1;
                map_wa  = r_clr;
                map_wd  = '1;
                page_we = 1'b1;
                page_wa = t_page'(r_clr);
                page_wd = '0;
                if (r_clr == t_slot'(TOTAL_ENTRIES - 1)) begin
                    n_state = S_IDLE;
                end else begin
                    n_clr = t_slot'(r_clr + 1'b1);
                end
            end
            S_IDLE: begin
                if (i_valid) begin
                    map_re  = 1'b1;
                    page_re = 1'b1;
                    n_state = S_RD;
                end
            end
            S_RD: begin
                n_hit   = cur_hit;
                res_hit = cur_hit;
                case (r_op)
                    OP_LOOKUP: begin
                        fin = 1'b1;
                        if (cur_hit) begin
                            res_phys = PHYS_W'(r_map_q);
                        end
                    end
                    OP_UPDATE: begin
                        fin = 1'b1;
                        if (out_free) begin
                            map_we = 1'b1;
                            if (cur_hit) begin
                                page_we       = 1'b1;
                                page_wd       = r_page_q;
                                page_wd.dirty = 1'b1;
                            end
                        end
                    end
                    OP_FILL: begin
                        if (full_now) begin
                            // start the victim walk from page zero
                            scan_req.clr = 1'b1;
                            n_idx        = '0;
                            n_state      = S_SCAN;
                        end else begin
                            fin = 1'b1;
                            if (out_free && fill_new) begin
                                page_we = 1'b1;
                                page_wd = fill_row;
                                n_total = t_tot'(r_total + 1'b1);
                            end
                        end
                    end
                    default: begin
                        fin = 1'b1;
                    end
                endcase
            end
            S_SCAN: begin
                if (r_idx != SCAN_W'(NUM_TPAGES)) begin
                    page_re = 1'b1;
                    page_ra = t_page'(r_idx);
                    n_idx   = SCAN_W'(r_idx + 1'b1);
                    n_sv    = 1'b1;
                    n_sidx  = t_page'(r_idx);
                end else begin
                    n_state = S_EVICT;
                end
            end
            S_EVICT: begin
                if (scan_res.found) begin
                    page_we = 1'b1;
                    page_wa = scan_res.page;
                    page_wd = '0;
                    if (r_total >= t_tot'(scan_res.best)) begin
                        n_total = t_tot'(r_total - t_tot'(scan_res.best));
                    end else begin
                        n_total = '0;
                    end
                end
                page_re = 1'b1;
                page_ra = r_page;
                n_state = S_FILL;
            end
            S_FILL: begin
                fin        = 1'b1;
                res_ev     = scan_res.found;
                res_vpage  = scan_res.found ? VPG_W'(scan_res.page) : '0;
                res_vdirty = scan_res.found && scan_res.dirty;
                if (out_free && fill_new) begin
                    page_we = 1'b1;
                    page_wd = fill_row;
                    n_total = t_tot'(r_total + 1'b1);
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase

        // finish only when the output register can take the result
        load = fin && out_free;
        if (load) begin
            n_state = S_IDLE;
        end
    end

    // map memory
    always_ff @(posedge i_clk) begin
        if (map_we) begin
            r_map_mem[map_wa] <= map_wd;
        end
        if (map_re) begin
            r_map_q <= r_map_mem[map_ra];
        end
    end

    // page memory
    always_ff @(posedge i_clk) begin
        if (page_we) begin
            r_page_mem[page_wa] <= page_wd;
        end
        if (page_re) begin
            r_page_q <= r_page_mem[page_ra];
        end
    end

    // control state
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_CLEAR;
            r_clr    <= '0;
            r_total  <= '0;
            r_max    <= MAX_CACHED_RST;
            r_idx    <= '0;
            r_sv     <= 1'b0;
            r_ovalid <= 1'b0;
        end else begin
            r_state <= n_state;
            r_clr   <= n_clr;
            r_total <= n_total;
            r_idx   <= n_idx;
            r_sv    <= n_sv;
            if (i_cfg_valid) begin
                r_max <= i_cfg_data;
            end
            if (load) begin
                r_ovalid <= 1'b1;
            end else if (i_ready) begin
                r_ovalid <= 1'b0;
            end
        end
    end

    // request and result payload
    always_ff @(posedge i_clk) begin
        r_hit  <= n_hit;
        r_sidx <= n_sidx;
        if (accept) begin
            r_op   <= i_opcode;
            r_page <= in_page;
            r_off  <= in_off;
            r_ppa  <= t_ppa'(i_new_phys_addr);
        end
        if (load) begin
            r_o_hit    <= res_hit;
            r_o_phys   <= res_phys;
            r_o_ev     <= res_ev;
            r_o_vpage  <= res_vpage;
            r_o_vdirty <= res_vdirty;
            r_o_full   <= (CMP_W'(n_total) >= CMP_W'(r_max));
        end
    end

    assign o_valid        = r_ovalid;
    assign o_hit          = r_o_hit;
    assign o_phys_addr    = r_o_phys;
    assign o_evicted      = r_o_ev;
    assign o_victim_page  = r_o_vpage;
    assign o_victim_dirty = r_o_vdirty;
    assign o_cache_full   = r_o_full;

    // a taken request always goes to the memory read cycle
    a_accept_reads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_valid && o_ready) |=> (r_state == S_RD))
        else $error("taken request did not enter the read cycle");

    // a nonzero address is only reported on a hit
    a_phys_on_hit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && (o_phys_addr != '0)) |-> o_hit)
        else $error("physical address reported without a hit");

    // victim fields stay zero without an eviction
    a_victim_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_valid && !o_evicted) |-> ((o_victim_page == '0) && !o_victim_dirty))
        else $error("victim reported without an eviction");

    // the fill step follows the eviction step
    a_fill_order: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_FILL) |-> (($past(r_state) == S_EVICT) || ($past(r_state) == S_FILL)))
        else $error("fill step entered out of order");

endmodule

[src/fgmc_victim_scan.sv]
// fgmc_victim_scan: running maximum over a stream of page counts
// keeps the first page with the greatest nonzero count; uses fgmc_pkg
module fgmc_victim_scan
    import fgmc_pkg::*;
(
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  t_scan_req i_req,
    output t_scan_res o_res
);

    logic  r_found;
    t_page r_page;
    t_pcnt r_best;
    logic  r_dirty;

    // strictly greater keeps the lowest index on a tie
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_found <= 1'b0;
            r_page  <= '0;
            r_best  <= '0;
            r_dirty <= 1'b0;
        end else if (i_req.clr) begin
            r_found <= 1'b0;
            r_page  <= '0;
            r_best  <= '0;
            r_dirty <= 1'b0;
        end else if (i_req.vld && (i_req.cnt > r_best)) begin
            r_found <= 1'b1;
            r_page  <= i_req.idx;
            r_best  <= i_req.cnt;
            r_dirty <= i_req.dirty;
        end
    end

    assign o_res = '{found: r_found, page: r_page, best: r_best, dirty: r_dirty};

endmodule
